### rtl/acf_pkg.sv
// Package: shared constants and types of the altitude complementary filter.
`timescale 1ns / 1ps
`default_nettype none
package acf_pkg;
	localparam int MEDIAN_TAPS = 5;
	localparam int REST_WINDOW = 20;
	localparam int MED_W = $clog2(MEDIAN_TAPS);
	localparam int REST_W = $clog2(REST_WINDOW);
	localparam logic [15:0] DT_LIMIT = 16'd6554;
	localparam logic signed [31:0] ACCEL_FLOOR = 32'sd3277;
	localparam logic [15:0] POS_GAIN_RST = 16'd7864;
	localparam logic [15:0] VEL_GAIN_RST = 16'd197;
	localparam logic [19:0] REST_TH_RST = 20'd9830;
	localparam logic [1:0] REG_POS_GAIN = 2'd0;
	localparam logic [1:0] REG_VEL_GAIN = 2'd1;
	localparam logic [1:0] REG_REST_TH = 2'd2;

	// Sequencer states, one-hot.
	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_DT2  = 9'b000000010,
		ST_VDT  = 9'b000000100,
		ST_ADT2 = 9'b000001000,
		ST_ADT  = 9'b000010000,
		ST_MED  = 9'b000100000,
		ST_KP   = 9'b001000000,
		ST_KI   = 9'b010000000,
		ST_OUT  = 9'b100000000
	} state_t;

	// Saturate a 34-bit sum to 32 bits.
	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v > 34'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
		else if (v < -34'sh0_8000_0000) r = 32'sh8000_0000;
		else r = v[31:0];
		return r;
	endfunction
endpackage
`default_nettype wire

### rtl/acf_mul.sv
// Shared signed multiplier with floor shift: 32 x 17 product, registered.
`timescale 1ns / 1ps
`default_nettype none
module acf_mul (
	input  wire logic               clk,
	input  wire logic signed [31:0] a,
	input  wire logic signed [16:0] b,
	input  wire logic               half,
	output logic signed [31:0]      p
);
	import acf_pkg::*;
	logic signed [48:0] prod;
	logic signed [48:0] prod_q;
	logic half_q;
	// Form the product; arithmetic shift is floor.
	assign prod = a * b;
	always_ff @(posedge clk) begin
		prod_q <= prod;
		half_q <= half;
	end
	// Results stay within 32 bits for both shift amounts.
	assign p = half_q ? 32'(prod_q >>> 17) : 32'(prod_q >>> 16);
endmodule
`default_nettype wire

### rtl/altitude_complementary_filter.sv
// Top level: altitude / vertical velocity complementary filter.
`timescale 1ns / 1ps
`default_nettype none
// One shared multiplier under a small sequencer handles each request. A skipped
// step (zero time step) goes straight from idle to the output state; any other
// passes through the product states in turn, using the single multiplier for
// dt*dt, v*dt, a*dt2, a*dt and the two gain products. The result waits in an
// output register; a new request is taken once it is delivered. Configuration
// over APB, registers at byte 0, 4, 8.
module altitude_complementary_filter (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [31:0] accel_vertical,
	input  wire logic signed [31:0] baro_altitude,
	input  wire logic        [15:0] time_step,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      altitude_estimate,
	output logic signed [31:0]      velocity_estimate,
	output logic                    at_rest,
	output logic                    step_skipped,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic        [3:0]  paddr,
	input  wire logic        [31:0] pwdata,
	output logic             [31:0] prdata,
	output logic                    pready
);
	import acf_pkg::*;

	state_t state_q;
	logic [15:0] pgain_q, vgain_q;
	logic [19:0] rth_q;
	logic signed [31:0] med_q [MEDIAN_TAPS];
	logic [MED_W-1:0] mslot_q;
	logic mfull_q;
	logic signed [31:0] rest_q [REST_WINDOW];
	logic [REST_W-1:0] rslot_q;
	logic signed [31:0] alt_q, vel_q, h_q, v_q, acc_q, baro_q, filt_q, err_q;
	logic [15:0] dt_q, dt2_q;
	logic skip_q;
	logic signed [31:0] mul_a, mul_p;
	logic signed [16:0] mul_b;
	logic mul_half;

	assign pready = 1'b1;
	assign in_ready = (state_q == ST_IDLE) && !out_valid;

	// Register read decode.
	always_comb begin
		unique case (paddr[3:2])
			REG_POS_GAIN: prdata = {16'd0, pgain_q};
			REG_VEL_GAIN: prdata = {16'd0, vgain_q};
			REG_REST_TH:  prdata = {12'd0, rth_q};
			default:      prdata = 32'd0;
		endcase
	end

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pgain_q <= POS_GAIN_RST;
			vgain_q <= VEL_GAIN_RST;
			rth_q <= REST_TH_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_POS_GAIN: pgain_q <= pwdata[15:0];
				REG_VEL_GAIN: vgain_q <= pwdata[15:0];
				REG_REST_TH:  rth_q <= pwdata[19:0];
				default: ;
			endcase
		end
	end

	// Select the multiplier operands for the state issuing a product.
	always_comb begin
		mul_a = acc_q;
		mul_b = {1'b0, dt_q};
		mul_half = 1'b0;
		unique case (state_q)
			ST_DT2:  mul_a = {16'd0, dt_q};
			ST_VDT:  mul_a = vel_q;
			ST_ADT2: begin mul_b = {1'b0, dt2_q}; mul_half = 1'b1; end
			ST_KP:   begin mul_a = err_q; mul_b = {1'b0, pgain_q}; end
			ST_KI:   begin mul_a = err_q; mul_b = {1'b0, vgain_q}; end
			default: ;
		endcase
	end

	acf_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .half(mul_half), .p(mul_p));

	// Median of the window: count elements ranked below each entry.
	logic signed [31:0] med_sel;
	always_comb begin
		int lt, le;
		med_sel = med_q[0];
		for (int i = 0; i < MEDIAN_TAPS; i++) begin
			lt = 0; le = 0;
			for (int j = 0; j < MEDIAN_TAPS; j++) begin
				if (med_q[j] < med_q[i]) lt++;
				if (med_q[j] <= med_q[i]) le++;
			end
			if (lt <= MEDIAN_TAPS / 2 && le > MEDIAN_TAPS / 2) med_sel = med_q[i];
		end
	end

	// Rest test over the ring.
	logic [REST_WINDOW-1:0] in_band;
	always_comb begin
		for (int i = 0; i < REST_WINDOW; i++)
			in_band[i] = !(33'(rest_q[i]) > $signed({13'd0, rth_q}) ||
				33'(rest_q[i]) < -$signed({13'd0, rth_q}));
	end

	logic signed [31:0] acc_eff;
	assign acc_eff = (acc_q < ACCEL_FLOOR && acc_q > -ACCEL_FLOOR) ? 32'sd0 : acc_q;
	logic signed [31:0] filt_now;
	assign filt_now = filt_q;

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid <= 1'b0;
			at_rest <= 1'b0;
			step_skipped <= 1'b0;
			mslot_q <= '0;
			mfull_q <= 1'b0;
			rslot_q <= '0;
			alt_q <= '0;
			vel_q <= '0;
			h_q <= '0;
			v_q <= '0;
			acc_q <= '0;
			baro_q <= '0;
			filt_q <= '0;
			err_q <= '0;
			dt_q <= '0;
			dt2_q <= '0;
			skip_q <= 1'b0;
			for (int i = 0; i < REST_WINDOW; i++) rest_q[i] <= '0;
			for (int i = 0; i < MEDIAN_TAPS; i++) med_q[i] <= '0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (in_valid && in_ready) begin
					rest_q[rslot_q] <= accel_vertical;
					rslot_q <= (rslot_q == REST_W'(REST_WINDOW - 1)) ? '0 : rslot_q + 1'b1;
					acc_q <= accel_vertical;
					baro_q <= baro_altitude;
					dt_q <= (time_step > DT_LIMIT) ? DT_LIMIT : time_step;
					skip_q <= (time_step == 16'd0);
					state_q <= (time_step == 16'd0) ? ST_OUT : ST_DT2;
				end
				ST_DT2: begin
					acc_q <= acc_eff;
					med_q[mslot_q] <= baro_q;
					if (mslot_q == MED_W'(MEDIAN_TAPS - 1)) begin
						mslot_q <= '0;
						mfull_q <= 1'b1;
					end else mslot_q <= mslot_q + 1'b1;
					state_q <= ST_VDT;
				end
				ST_VDT: begin
					dt2_q <= mul_p[15:0];
					filt_q <= mfull_q ? med_sel : baro_q;
					state_q <= ST_ADT2;
				end
				ST_ADT2: begin
					h_q <= sat32(34'(alt_q) + 34'(mul_p));
					state_q <= ST_ADT;
				end
				ST_ADT: begin
					h_q <= sat32(34'(h_q) + 34'(mul_p));
					state_q <= ST_MED;
				end
				ST_MED: begin
					v_q <= sat32(34'(vel_q) + 34'(mul_p));
					err_q <= sat32(34'(filt_now) - 34'(h_q));
					state_q <= ST_KP;
				end
				ST_KP: state_q <= ST_KI;
				ST_KI: begin
					alt_q <= sat32(34'(h_q) + 34'(mul_p));
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!skip_q)
						vel_q <= (&in_band) ? 32'sd0 : sat32(34'(v_q) + 34'(mul_p));
					at_rest <= !skip_q && (&in_band);
					step_skipped <= skip_q;
					out_valid <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign altitude_estimate = alt_q;
	assign velocity_estimate = vel_q;
endmodule
`default_nettype wire

### rtl/acf_checker.sv
// Checker: port-level properties of the filter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module acf_port_props (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic step_skipped,
	input wire logic at_rest,
	input wire logic pready
);
	// No request taken while a result waits.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("request taken while result pending");
	// A skipped step never reports rest.
	a_skip_rest: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && step_skipped |-> !at_rest) else $error("rest on skipped step");
	// Result not ready the cycle after acceptance.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid) else $error("result too early");
	// Held result stays valid.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_pready: assert property (@(posedge clk) pready) else $error("pready low");
endmodule

bind altitude_complementary_filter acf_port_props u_acf_port_props (.*);
`default_nettype wire
